### design/es2c_pkg.sv
// ---------------------------------------------------------------------------
// es2c_pkg
// Shared types, constants and calendar tables for the epoch-to-calendar core.
// ---------------------------------------------------------------------------
package es2c_pkg;

  localparam int T_W     = 32;
  localparam int EPOCH_W = 31;
  localparam int ZONE_W  = 16;
  localparam int YEAR_W  = 11;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int QUO_W   = 6;
  localparam int SH_W    = 3;

  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic [APB_AW-3:0] REG_ZONE = '0;

  localparam logic [ZONE_W-1:0]  ZONE_RESET = ZONE_W'(8 * 60 * 60);
  localparam logic [YEAR_W-1:0]  EPOCH_YEAR = YEAR_W'(1970);
  localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR  = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN  = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP  = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV  = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);

  localparam int SECS_PER_DAY_I = 24 * 60 * 60;
  localparam logic [T_W-1:0] SECS_PER_DAY  = T_W'(SECS_PER_DAY_I);
  localparam logic [T_W-1:0] SECS_PER_HOUR = T_W'(60 * 60);
  localparam logic [T_W-1:0] SECS_PER_MIN  = T_W'(60);
  localparam logic [T_W-1:0] YEAR365_SECS  = T_W'(365 * SECS_PER_DAY_I);
  localparam logic [T_W-1:0] YEAR366_SECS  = T_W'(366 * SECS_PER_DAY_I);
  localparam logic [T_W-1:0] MON28_SECS    = T_W'(28 * SECS_PER_DAY_I);
  localparam logic [T_W-1:0] MON29_SECS    = T_W'(29 * SECS_PER_DAY_I);
  localparam logic [T_W-1:0] MON30_SECS    = T_W'(30 * SECS_PER_DAY_I);
  localparam logic [T_W-1:0] MON31_SECS    = T_W'(31 * SECS_PER_DAY_I);

  // year mod 4 / 100 / 400 of the epoch year
  localparam logic [1:0] EPOCH_MOD4   = 2'(1970 % 4);
  localparam logic [6:0] EPOCH_MOD100 = 7'(1970 % 100);
  localparam logic [8:0] EPOCH_MOD400 = 9'(1970 % 400);

  typedef struct packed {
    logic           ge;
    logic [T_W-1:0] diff;
  } es2c_sub_t;

  function automatic logic [T_W-1:0] month_secs(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [T_W-1:0] len;
    case (m)
      MONTH_FEB:                                len = leap ? MON29_SECS : MON28_SECS;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = MON30_SECS;
      default:                                  len = MON31_SECS;
    endcase
    return len;
  endfunction

endpackage

### design/epoch_seconds_to_calendar_core.sv
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Epoch seconds plus zone offset to Gregorian year, month, day and time.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result follows
// on out_valid for a single cycle and must be captured then. A single
// compare-subtract unit does all the work, one step per clock: one step per
// whole year stripped plus one, one per whole month stripped plus one (at
// most 12), then 5 + 5 + 6 restoring-division steps for day, hour and minute.
// busy stays high until the result cycle, in which a new request may be
// taken. The zone offset register sits at byte address 0.
// ---------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [es2c_pkg::EPOCH_W-1:0] in_epoch_seconds,
  output logic                         out_valid,
  output logic [es2c_pkg::YEAR_W-1:0]  out_year_value,
  output logic [es2c_pkg::MONTH_W-1:0] out_month_value,
  output logic [es2c_pkg::DAY_W-1:0]   out_day_of_month,
  output logic [es2c_pkg::HOUR_W-1:0]  out_hour_value,
  output logic [es2c_pkg::MIN_W-1:0]   out_minute_value,
  output logic [es2c_pkg::SEC_W-1:0]   out_second_value,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [es2c_pkg::APB_AW-1:0]  paddr,
  input  logic [es2c_pkg::APB_DW-1:0]  pwdata,
  output logic [es2c_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import es2c_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_YEAR, ST_MONTH, ST_DAY, ST_HOUR, ST_MIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [T_W-1:0]     t_r, t_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [1:0]         mod4_r, mod4_nxt;
  logic [6:0]         mod100_r, mod100_nxt;
  logic [8:0]         mod400_r, mod400_nxt;
  logic [SH_W-1:0]    sh_r, sh_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [HOUR_W-1:0]  hour_r, hour_nxt;
  logic [MIN_W-1:0]   min_r, min_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic               valid_r, valid_nxt;

  logic [ZONE_W-1:0]  zone_offset;
  logic               leap;
  logic               accept;
  logic [T_W-1:0]     len;
  logic [QUO_W-1:0]   quo_step;
  es2c_sub_t          sub;

  es2c_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .zone_offset (zone_offset)
  );

  es2c_alu u_alu (
    .rem (t_r),
    .len (len),
    .res (sub)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign leap     = ((mod4_r == 2'd0) && (mod100_r != 7'd0)) || (mod400_r == 9'd0);
  assign quo_step = {quo_r[QUO_W-2:0], sub.ge};

  always_comb begin
    case (state_r)
      ST_YEAR:  len = leap ? YEAR366_SECS : YEAR365_SECS;
      ST_MONTH: len = month_secs(month_r, leap);
      ST_DAY:   len = SECS_PER_DAY << sh_r;
      ST_HOUR:  len = SECS_PER_HOUR << sh_r;
      ST_MIN:   len = SECS_PER_MIN << sh_r;
      default:  len = '0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    t_nxt      = t_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    mod4_nxt   = mod4_r;
    mod100_nxt = mod100_r;
    mod400_nxt = mod400_r;
    sh_nxt     = sh_r;
    quo_nxt    = quo_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    valid_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          t_nxt      = T_W'(in_epoch_seconds) + T_W'(zone_offset);
          year_nxt   = EPOCH_YEAR;
          month_nxt  = MONTH_JAN;
          mod4_nxt   = EPOCH_MOD4;
          mod100_nxt = EPOCH_MOD100;
          mod400_nxt = EPOCH_MOD400;
          state_nxt  = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sub.ge) begin
          t_nxt      = sub.diff;
          year_nxt   = year_r + 1'b1;
          mod4_nxt   = mod4_r + 1'b1;
          mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 1'b1;
          mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 1'b1;
        end else begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (sub.ge) begin
          t_nxt = sub.diff;
          if (month_r != MONTH_DEC) begin
            month_nxt = month_r + 1'b1;
          end
        end
        if (!sub.ge || month_r == MONTH_DEC) begin
          state_nxt = ST_DAY;
          sh_nxt    = SH_W'(4);
          quo_nxt   = '0;
        end
      end
      ST_DAY: begin
        if (sub.ge) t_nxt = sub.diff;
        quo_nxt = quo_step;
        sh_nxt  = sh_r - 1'b1;
        if (sh_r == '0) begin
          day_nxt   = quo_step[DAY_W-1:0] + 1'b1;
          quo_nxt   = '0;
          sh_nxt    = SH_W'(4);
          state_nxt = ST_HOUR;
        end
      end
      ST_HOUR: begin
        if (sub.ge) t_nxt = sub.diff;
        quo_nxt = quo_step;
        sh_nxt  = sh_r - 1'b1;
        if (sh_r == '0) begin
          hour_nxt  = quo_step[HOUR_W-1:0];
          quo_nxt   = '0;
          sh_nxt    = SH_W'(5);
          state_nxt = ST_MIN;
        end
      end
      ST_MIN: begin
        if (sub.ge) t_nxt = sub.diff;
        quo_nxt = quo_step;
        sh_nxt  = sh_r - 1'b1;
        if (sh_r == '0) begin
          min_nxt   = quo_step[MIN_W-1:0];
          sec_nxt   = sub.ge ? sub.diff[SEC_W-1:0] : t_r[SEC_W-1:0];
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    t_r      <= t_nxt;
    year_r   <= year_nxt;
    month_r  <= month_nxt;
    mod4_r   <= mod4_nxt;
    mod100_r <= mod100_nxt;
    mod400_r <= mod400_nxt;
    sh_r     <= sh_nxt;
    quo_r    <= quo_nxt;
    day_r    <= day_nxt;
    hour_r   <= hour_nxt;
    min_r    <= min_nxt;
    sec_r    <= sec_nxt;
  end

  assign out_valid        = valid_r;
  assign out_year_value   = year_r;
  assign out_month_value  = month_r;
  assign out_day_of_month = day_r;
  assign out_hour_value   = hour_r;
  assign out_minute_value = min_r;
  assign out_second_value = sec_r;

  a_result_after_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_MIN) && !busy)
    else $error("result strobe without finishing minute step");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request accepted but block not busy");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_value >= MONTH_JAN) && (out_month_value <= MONTH_DEC) &&
                  (out_day_of_month != '0) && (out_hour_value < HOUR_W'(24)) &&
                  (out_minute_value < MIN_W'(60)) && (out_second_value < SEC_W'(60)))
    else $error("calendar result out of range");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOUR) && (sh_r == SH_W'(4)) |-> t_r < SECS_PER_DAY)
    else $error("day remainder not below one day");

endmodule

### design/es2c_cfg.sv
// ---------------------------------------------------------------------------
// es2c_cfg
// APB register file holding the time-zone offset.
// ---------------------------------------------------------------------------
module es2c_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [es2c_pkg::APB_AW-1:0] paddr,
  input  logic [es2c_pkg::APB_DW-1:0] pwdata,
  output logic [es2c_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [es2c_pkg::ZONE_W-1:0] zone_offset
);
  import es2c_pkg::*;

  logic [ZONE_W-1:0] zone_r;
  logic              hit_zone;

  assign hit_zone    = (paddr[APB_AW-1:2] == REG_ZONE);
  assign pready      = 1'b1;
  assign zone_offset = zone_r;
  assign prdata      = hit_zone ? APB_DW'(zone_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= ZONE_RESET;
    end else if (psel && penable && pwrite && hit_zone) begin
      zone_r <= pwdata[ZONE_W-1:0];
    end
  end

endmodule

### design/es2c_alu.sv
// ---------------------------------------------------------------------------
// es2c_alu
// Shared compare-subtract unit: remainder minus a step length.
// ---------------------------------------------------------------------------
module es2c_alu (
  input  logic [es2c_pkg::T_W-1:0] rem,
  input  logic [es2c_pkg::T_W-1:0] len,
  output es2c_pkg::es2c_sub_t      res
);
  import es2c_pkg::*;

  logic [T_W:0] d;

  assign d        = {1'b0, rem} - {1'b0, len};
  assign res.ge   = ~d[T_W];
  assign res.diff = d[T_W-1:0];

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for epoch_seconds_to_calendar_core. Requests go in on
// the start/busy handshake; each returned date is compared with the date its
// table row gives, else with a behavioral calendar conversion in the bench.
// A short table of dated corner cases runs first. Random phases follow, each
// under its own zone offset, with the requester idling at different rates.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import es2c_pkg::*;

  localparam int unsigned DAY_SECS = 86400;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_PER_PHASE = 334;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS = 10;
  localparam logic [APB_AW-3:0] REG_UNUSED = 1'b1;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } calendar_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [APB_AW-3:0] reg_idx;
    logic [APB_DW-1:0] value;
    logic              has_cal;
    calendar_t         cal;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [23] = '{
    '{ROW_REQ, REG_ZONE,   32'd0,          1'b1, '{11'd1970, 4'd1,  5'd1,  5'd8,  6'd0,  6'd0}},
    '{ROW_REQ, REG_ZONE,   32'h7FFF_FFFF,  1'b1, '{11'd2038, 4'd1,  5'd19, 5'd11, 6'd14, 6'd7}},
    '{ROW_CFG, REG_ZONE,   32'hFFFF_0000,  1'b0, '0},
    '{ROW_REQ, REG_ZONE,   32'd0,          1'b1, '{11'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{ROW_REQ, REG_ZONE,   32'h7FFF_FFFF,  1'b1, '{11'd2038, 4'd1,  5'd19, 5'd3,  6'd14, 6'd7}},
    '{ROW_REQ, REG_ZONE,   32'd86399,      1'b1, '{11'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59}},
    '{ROW_REQ, REG_ZONE,   32'd31535999,   1'b1, '{11'd1970, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{ROW_REQ, REG_ZONE,   32'd31536000,   1'b1, '{11'd1971, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{ROW_REQ, REG_ZONE,   32'd68212800,   1'b1, '{11'd1972, 4'd2,  5'd29, 5'd12, 6'd0,  6'd0}},
    // leap year with under 366 days left stays in that year
    '{ROW_REQ, REG_ZONE,   32'd94608000,   1'b1, '{11'd1972, 4'd12, 5'd31, 5'd0,  6'd0,  6'd0}},
    '{ROW_REQ, REG_ZONE,   32'd94694399,   1'b1, '{11'd1972, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{ROW_REQ, REG_ZONE,   32'd946684799,  1'b1, '{11'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{ROW_REQ, REG_ZONE,   32'd951782400,  1'b1, '{11'd2000, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0}},
    '{ROW_REQ, REG_ZONE,   32'd978307199,  1'b1, '{11'd2000, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{ROW_CFG, REG_ZONE,   32'h0000_FFFF,  1'b0, '0},
    '{ROW_REQ, REG_ZONE,   32'd0,          1'b1, '{11'd1970, 4'd1,  5'd1,  5'd18, 6'd12, 6'd15}},
    '{ROW_REQ, REG_ZONE,   32'h7FFF_FFFF,  1'b1, '{11'd2038, 4'd1,  5'd19, 5'd21, 6'd26, 6'd22}},
    // write to a register that does not exist must leave the offset alone
    '{ROW_CFG, REG_UNUSED, 32'h0000_1234,  1'b0, '0},
    '{ROW_REQ, REG_ZONE,   32'd3600,       1'b0, '0},
    '{ROW_CFG, REG_ZONE,   32'hA5A5_C4E0,  1'b0, '0},
    '{ROW_REQ, REG_ZONE,   32'd0,          1'b1, '{11'd1970, 4'd1,  5'd1,  5'd14, 6'd0,  6'd0}},
    '{ROW_REQ, REG_ZONE,   32'h2AAA_AAAA,  1'b0, '0},
    '{ROW_REQ, REG_ZONE,   32'h5555_5555,  1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [EPOCH_W-1:0]   in_epoch_seconds = '0;
  logic                 out_valid;
  logic [YEAR_W-1:0]    out_year_value;
  logic [MONTH_W-1:0]   out_month_value;
  logic [DAY_W-1:0]     out_day_of_month;
  logic [HOUR_W-1:0]    out_hour_value;
  logic [MIN_W-1:0]     out_minute_value;
  logic [SEC_W-1:0]     out_second_value;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  logic [ZONE_W-1:0]    zone_now = ZONE_RESET;
  int                   sender_idle_pct = 0;
  calendar_t            pending_dates [$];
  calendar_t            observed_date;
  calendar_t            want_date;
  int                   error_count = 0;
  int unsigned          cycle_count = 0;

  epoch_seconds_to_calendar_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_year_value   (out_year_value),
    .out_month_value  (out_month_value),
    .out_day_of_month (out_day_of_month),
    .out_hour_value   (out_hour_value),
    .out_minute_value (out_minute_value),
    .out_second_value (out_second_value),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  assign observed_date = {out_year_value, out_month_value, out_day_of_month,
                          out_hour_value, out_minute_value, out_second_value};

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input bit leap);
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // seconds from the epoch to the first second of year y, month m
  function automatic longint unsigned month_start(input int unsigned y, input int unsigned m);
    longint unsigned s;
    int unsigned k;
    s = 0;
    for (k = 1970; k < y; k++)
      s += longint'(is_leap(k) ? 366 : 365) * DAY_SECS;
    for (k = 1; k < m; k++)
      s += longint'(month_days(k, is_leap(y))) * DAY_SECS;
    return s;
  endfunction

  function automatic calendar_t to_calendar(input logic [EPOCH_W-1:0] epoch,
                                            input logic [ZONE_W-1:0] zone);
    longint unsigned t;
    longint unsigned span;
    int unsigned yr;
    int unsigned mo;
    calendar_t c;
    t = epoch;
    t += zone;
    yr = 1970;
    forever begin
      span = longint'(is_leap(yr) ? 366 : 365) * DAY_SECS;
      if (t < span) break;
      t -= span;
      yr++;
    end
    mo = 1;
    forever begin
      span = longint'(month_days(mo, is_leap(yr))) * DAY_SECS;
      if (t < span || mo == 12) break;
      t -= span;
      mo++;
    end
    c.year   = YEAR_W'(yr);
    c.month  = MONTH_W'(mo);
    c.day    = DAY_W'(t / DAY_SECS + 1);
    t        = t % DAY_SECS;
    c.hour   = HOUR_W'(t / 3600);
    c.minute = MIN_W'((t % 3600) / 60);
    c.second = SEC_W'(t % 60);
    return c;
  endfunction

  // half uniform, half clustered around local month and year boundaries
  function automatic logic [EPOCH_W-1:0] pick_epoch(input logic [ZONE_W-1:0] zone);
    longint s;
    if ($urandom_range(1) == 0)
      return EPOCH_W'($urandom);
    s = longint'(month_start($urandom_range(1970, 2038), $urandom_range(1, 12)));
    s = s - zone + $urandom_range(0, 4 * DAY_SECS) - 2 * DAY_SECS;
    if (s < 0)
      s = 0;
    if (s > 64'h7FFF_FFFF)
      s = 64'h7FFF_FFFF;
    return EPOCH_W'(s);
  endfunction

  function automatic void report_error(input string what, input calendar_t want,
                                       input calendar_t got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR %s: expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
               what, want.year, want.month, want.day, want.hour, want.minute, want.second,
               got.year, got.month, got.day, got.hour, got.minute, got.second);
  endfunction

  // start flickers with the idle rate until the request is taken
  task automatic send_request(input logic [EPOCH_W-1:0] epoch, input calendar_t want);
    bit go;
    in_epoch_seconds <= epoch;
    forever begin
      go = ($urandom_range(99) >= sender_idle_pct);
      start <= go;
      @(posedge clk);
      if (go && !busy) break;
    end
    pending_dates.push_back(want);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_dates.size() != 0 || busy)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [APB_AW-3:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ZONE)
      zone_now = ZONE_W'(data);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        report_error("unexpected result", '0, observed_date);
      end else begin
        want_date = pending_dates.pop_front();
        if (want_date != observed_date)
          report_error("date mismatch", want_date, observed_date);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d requests outstanding", pending_dates.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    logic [EPOCH_W-1:0] epoch;
    int phase;
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      epoch = row.value[EPOCH_W-1:0];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.reg_idx, row.value);
      end else begin
        send_request(epoch, row.has_cal ? row.cal : to_calendar(epoch, zone_now));
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      settle();
      if (phase == 1)
        write_reg(REG_ZONE, {16'($urandom), 16'($urandom)});
      else
        write_reg(REG_ZONE, {16'($urandom), 16'($urandom_range(0, 50400))});
      sender_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 85 : 0;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        epoch = pick_epoch(zone_now);
        send_request(epoch, to_calendar(epoch, zone_now));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
